@@ hw/rtl/trc_pkg.sv @@
`timescale 1ns / 1ps

package trc_pkg;

  localparam int unsigned LETTERS = 26;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;
  localparam logic [4:0]  POS_LAST = 5'(LETTERS - 1);

  typedef enum logic [1:0] {
    REG_ROTOR_ORDER  = 2'd0,
    REG_START_FAST   = 2'd1,
    REG_START_MIDDLE = 2'd2,
    REG_START_SLOW   = 2'd3
  } trc_reg_t;

  typedef enum logic [2:0] {
    ORDER_123 = 3'd0,
    ORDER_213 = 3'd1,
    ORDER_231 = 3'd2,
    ORDER_312 = 3'd3,
    ORDER_321 = 3'd4,
    ORDER_132 = 3'd5
  } trc_order_t;

  typedef enum logic [1:0] {
    WHEEL_I   = 2'd0,
    WHEEL_II  = 2'd1,
    WHEEL_III = 2'd2
  } trc_wheel_t;

  typedef struct packed {
    logic [2:0] rotor_order;
    logic [4:0] start_fast;
    logic [4:0] start_middle;
    logic [4:0] start_slow;
  } trc_cfg_t;

  typedef struct packed {
    logic [4:0] fast;
    logic [4:0] middle;
    logic [4:0] slow;
  } trc_pos_t;

  typedef struct packed {
    logic step;
    logic load;
  } trc_ev_t;

  typedef struct packed {
    trc_wheel_t fast;
    trc_wheel_t middle;
    trc_wheel_t slow;
  } trc_wheels_t;

  localparam logic [4:0] FWD_I [LETTERS] = '{
    5'd21, 5'd4, 5'd19, 5'd0, 5'd1, 5'd25, 5'd10, 5'd23, 5'd20, 5'd8, 5'd16, 5'd18, 5'd5,
    5'd9, 5'd3, 5'd11, 5'd22, 5'd7, 5'd14, 5'd2, 5'd13, 5'd12, 5'd24, 5'd17, 5'd6, 5'd15
  };
  localparam logic [4:0] INV_I [LETTERS] = '{
    5'd3, 5'd4, 5'd19, 5'd14, 5'd1, 5'd12, 5'd24, 5'd17, 5'd9, 5'd13, 5'd6, 5'd15, 5'd21,
    5'd20, 5'd18, 5'd25, 5'd10, 5'd23, 5'd11, 5'd2, 5'd8, 5'd0, 5'd16, 5'd7, 5'd22, 5'd5
  };
  localparam logic [4:0] FWD_II [LETTERS] = '{
    5'd10, 5'd2, 5'd20, 5'd12, 5'd22, 5'd8, 5'd6, 5'd15, 5'd18, 5'd9, 5'd14, 5'd13, 5'd7,
    5'd5, 5'd19, 5'd23, 5'd11, 5'd4, 5'd24, 5'd1, 5'd21, 5'd17, 5'd16, 5'd0, 5'd25, 5'd3
  };
  localparam logic [4:0] INV_II [LETTERS] = '{
    5'd23, 5'd19, 5'd1, 5'd25, 5'd17, 5'd13, 5'd6, 5'd12, 5'd5, 5'd9, 5'd0, 5'd16, 5'd3,
    5'd11, 5'd10, 5'd7, 5'd22, 5'd21, 5'd8, 5'd14, 5'd2, 5'd20, 5'd4, 5'd15, 5'd18, 5'd24
  };
  localparam logic [4:0] FWD_III [LETTERS] = '{
    5'd10, 5'd7, 5'd18, 5'd2, 5'd23, 5'd1, 5'd11, 5'd13, 5'd25, 5'd4, 5'd8, 5'd24, 5'd22,
    5'd5, 5'd14, 5'd20, 5'd16, 5'd9, 5'd21, 5'd17, 5'd19, 5'd15, 5'd0, 5'd6, 5'd3, 5'd12
  };
  localparam logic [4:0] INV_III [LETTERS] = '{
    5'd22, 5'd5, 5'd3, 5'd24, 5'd9, 5'd13, 5'd23, 5'd1, 5'd10, 5'd17, 5'd0, 5'd6, 5'd25,
    5'd7, 5'd14, 5'd21, 5'd16, 5'd19, 5'd2, 5'd20, 5'd15, 5'd18, 5'd12, 5'd4, 5'd11, 5'd8
  };
  localparam logic [4:0] PLUG [LETTERS] = '{
    5'd1, 5'd0, 5'd3, 5'd2, 5'd5, 5'd4, 5'd6, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
    5'd13, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd20, 5'd25, 5'd22, 5'd23, 5'd24, 5'd21
  };

  function automatic logic [4:0] fold26(input logic [4:0] v);
    return (v >= 5'(LETTERS)) ? v - 5'(LETTERS) : v;
  endfunction

  function automatic logic [4:0] add26(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 6'(LETTERS)) ? 5'(s - 6'(LETTERS)) : s[4:0];
  endfunction

  function automatic logic [4:0] sub26(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] d;
    d = {1'b0, a} + 6'(LETTERS) - {1'b0, b};
    return (a >= b) ? a - b : d[4:0];
  endfunction

  function automatic logic [4:0] plug_swap(input logic [4:0] x);
    return PLUG[x];
  endfunction

  function automatic logic [4:0] reflect(input logic [4:0] x);
    return add26(x, 5'd13);
  endfunction

  function automatic logic [4:0] rotor_fwd(input trc_wheel_t w, input logic [4:0] x,
                                           input logic [4:0] p);
    logic [4:0] i;
    logic [4:0] r;
    i = add26(x, p);
    unique case (w)
      WHEEL_I:   r = FWD_I[i];
      WHEEL_II:  r = FWD_II[i];
      WHEEL_III: r = FWD_III[i];
      default:   r = FWD_I[i];
    endcase
    return r;
  endfunction

  function automatic logic [4:0] rotor_back(input trc_wheel_t w, input logic [4:0] y,
                                            input logic [4:0] p);
    logic [4:0] i;
    unique case (w)
      WHEEL_I:   i = INV_I[y];
      WHEEL_II:  i = INV_II[y];
      WHEEL_III: i = INV_III[y];
      default:   i = INV_I[y];
    endcase
    return sub26(i, p);
  endfunction

  function automatic trc_wheels_t order_wheels(input logic [2:0] order);
    trc_wheels_t w;
    unique case (trc_order_t'(order))
      ORDER_123: w = '{WHEEL_I,   WHEEL_II,  WHEEL_III};
      ORDER_213: w = '{WHEEL_II,  WHEEL_I,   WHEEL_III};
      ORDER_231: w = '{WHEEL_II,  WHEEL_III, WHEEL_I};
      ORDER_312: w = '{WHEEL_III, WHEEL_I,   WHEEL_II};
      ORDER_321: w = '{WHEEL_III, WHEEL_II,  WHEEL_I};
      ORDER_132: w = '{WHEEL_I,   WHEEL_III, WHEEL_II};
      default:   w = '{WHEEL_I,   WHEEL_II,  WHEEL_III};
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/trc_if.sv @@
`timescale 1ns / 1ps

interface trc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [4:0] letter_in;

  modport source (output valid, output kind, output letter_in, input ready);
  modport sink (input valid, input kind, input letter_in, output ready);
endinterface

interface trc_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] letter_out;

  modport source (output valid, output letter_out, input ready);
  modport sink (input valid, input letter_out, output ready);
endinterface

@@ hw/rtl/trc_regs.sv @@
`timescale 1ns / 1ps

module trc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [trc_pkg::ADDR_W-1:0]  paddr,
  input  logic [trc_pkg::DATA_W-1:0]  pwdata,
  output logic [trc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output trc_pkg::trc_cfg_t           cfg
);

  logic             wr_en;
  trc_pkg::trc_reg_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = trc_pkg::trc_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (sel)
        trc_pkg::REG_ROTOR_ORDER:  cfg.rotor_order  <= pwdata[2:0];
        trc_pkg::REG_START_FAST:   cfg.start_fast   <= pwdata[4:0];
        trc_pkg::REG_START_MIDDLE: cfg.start_middle <= pwdata[4:0];
        trc_pkg::REG_START_SLOW:   cfg.start_slow   <= pwdata[4:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      trc_pkg::REG_ROTOR_ORDER:  prdata = {29'd0, cfg.rotor_order};
      trc_pkg::REG_START_FAST:   prdata = {27'd0, cfg.start_fast};
      trc_pkg::REG_START_MIDDLE: prdata = {27'd0, cfg.start_middle};
      trc_pkg::REG_START_SLOW:   prdata = {27'd0, cfg.start_slow};
    endcase
  end

endmodule

@@ hw/rtl/trc_rotor_ctrl.sv @@
`timescale 1ns / 1ps

module trc_rotor_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  trc_pkg::trc_cfg_t  cfg,
  input  trc_pkg::trc_ev_t   ev,
  output trc_pkg::trc_pos_t  pos
);

  trc_pkg::trc_pos_t pos_next;

  always_comb begin
    pos_next = pos;
    if (ev.load) begin
      pos_next.fast   = trc_pkg::fold26(cfg.start_fast);
      pos_next.middle = trc_pkg::fold26(cfg.start_middle);
      pos_next.slow   = trc_pkg::fold26(cfg.start_slow);
    end else if (ev.step) begin
      if (pos.fast == trc_pkg::POS_LAST) begin
        pos_next.fast = '0;
        if (pos.middle == trc_pkg::POS_LAST) begin
          pos_next.middle = '0;
          pos_next.slow   = (pos.slow == trc_pkg::POS_LAST) ? 5'd0 : pos.slow + 5'd1;
        end else begin
          pos_next.middle = pos.middle + 5'd1;
        end
      end else begin
        pos_next.fast = pos.fast + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

@@ hw/rtl/trc_datapath.sv @@
`timescale 1ns / 1ps

module trc_datapath (
  input  logic               clk,
  input  logic               rst,
  trc_in_if.sink             item,
  trc_out_if.source          result,
  input  logic [2:0]         rotor_order,
  input  trc_pkg::trc_pos_t  pos,
  output trc_pkg::trc_ev_t   ev
);

  logic              s1_valid;
  logic [4:0]        s1_letter;
  trc_pkg::trc_pos_t s1_pos;
  logic              out_valid;
  logic [4:0]        out_letter;
  logic              s1_adv;
  logic              acc;
  trc_pkg::trc_wheels_t wh;
  logic [4:0]        x0, x1, x2, x3, x4, x5, x6, x7, x8;

  assign s1_adv     = !out_valid || result.ready;
  assign item.ready = !s1_valid || s1_adv;
  assign acc        = item.valid && item.ready;
  assign ev.step    = acc && !item.kind;
  assign ev.load    = acc && item.kind;

  assign result.valid      = out_valid;
  assign result.letter_out = out_letter;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= ev.step;
    end
  end

  always_ff @(posedge clk) begin
    if (ev.step) begin
      s1_letter <= trc_pkg::fold26(item.letter_in);
      s1_pos    <= pos;
    end
  end

  always_comb begin
    wh = trc_pkg::order_wheels(rotor_order);
    x0 = trc_pkg::plug_swap(s1_letter);
    x1 = trc_pkg::rotor_fwd(wh.fast, x0, s1_pos.fast);
    x2 = trc_pkg::rotor_fwd(wh.middle, x1, s1_pos.middle);
    x3 = trc_pkg::rotor_fwd(wh.slow, x2, s1_pos.slow);
    x4 = trc_pkg::reflect(x3);
    x5 = trc_pkg::rotor_back(wh.slow, x4, s1_pos.slow);
    x6 = trc_pkg::rotor_back(wh.middle, x5, s1_pos.middle);
    x7 = trc_pkg::rotor_back(wh.fast, x6, s1_pos.fast);
    x8 = trc_pkg::plug_swap(x7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_letter <= x8;
    end
  end

endmodule

@@ hw/rtl/three_rotor_cipher.sv @@
`timescale 1ns / 1ps

// channel  dir  payload               accepted when
// item     in   kind, letter_in       item.valid && item.ready
// result   out  letter_out            result.valid && result.ready
// apb      in   paddr, pwdata, prdata psel && penable && pwrite (pready = 1)
//
// One transaction per cycle while the result is not stalled; an accepted letter goes to the input register first.
// The rotor path is combinational between the input register and the result register.
// Restart transactions reload the positions and produce no result.
// A stalled result holds; the input register keeps taking transactions while it is free.
// Reset clears control, the configuration registers and all positions to 0; the letter registers are not reset.

module three_rotor_cipher (
  input  logic                        clk,
  input  logic                        rst,
  trc_in_if.sink                      item,
  trc_out_if.source                   result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [trc_pkg::ADDR_W-1:0]  paddr,
  input  logic [trc_pkg::DATA_W-1:0]  pwdata,
  output logic [trc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  trc_pkg::trc_cfg_t cfg;
  trc_pkg::trc_pos_t pos;
  trc_pkg::trc_ev_t  ev;

  trc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  trc_rotor_ctrl u_rotor_ctrl (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .ev  (ev),
    .pos (pos)
  );

  trc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .result      (result),
    .rotor_order (cfg.rotor_order),
    .pos         (pos),
    .ev          (ev)
  );

endmodule

@@ hw/rtl/trc_checker.sv @@
`timescale 1ns / 1ps

module trc_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       item_kind,
  input logic [4:0] item_letter_in,
  input logic       result_valid,
  input logic       result_ready,
  input logic [4:0] result_letter_out
);

  logic item_letter_acc;
  assign item_letter_acc = item_valid && item_ready && !item_kind;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_letter_out))
    else $error("result changed while stalled");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_letter_out < 5'd26)
    else $error("result letter out of range");

  a_no_self_map: assert property (@(posedge clk) disable iff (rst)
    (item_letter_acc && item_letter_in < 5'd26) ##1 result_ready
      |=> result_valid && result_letter_out != $past(item_letter_in, 2))
    else $error("letter missing or mapped to itself");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

bind three_rotor_cipher trc_checker u_trc_checker (
  .clk               (clk),
  .rst               (rst),
  .item_valid        (item.valid),
  .item_ready        (item.ready),
  .item_kind         (item.kind),
  .item_letter_in    (item.letter_in),
  .result_valid      (result.valid),
  .result_ready      (result.ready),
  .result_letter_out (result.letter_out)
);

@@ tb/sv/three_rotor_cipher_test.sv @@
`timescale 1ns / 1ps

module three_rotor_cipher_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam byte LETTER_A = 8'h61;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [trc_pkg::ADDR_W-1:0] paddr;
  logic [trc_pkg::DATA_W-1:0] pwdata;
  logic [trc_pkg::DATA_W-1:0] prdata;
  logic pready;

  trc_in_if item_ch ();
  trc_out_if result_ch ();

  three_rotor_cipher dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  string wheel_wiring [3] = '{
    "vetabzkxuiqsfjdlwhocnmyrgp",
    "kcumwigpsjonhftxleybvrqazd",
    "khscxblnzeiywfouqjvrtpagdm"
  };
  int plugboard [26] = '{1, 0, 3, 2, 5, 4, 6, 14, 15, 16, 17, 18, 19,
                         13, 7, 8, 9, 10, 11, 12, 20, 25, 22, 23, 24, 21};

  logic [2:0] cfg_order;
  logic [4:0] cfg_start [3];
  int rot_pos [3];
  logic [4:0] pending_letters [$];

  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int fold26_tb(input logic [4:0] v);
    return (v >= 26) ? int'(v) - 26 : int'(v);
  endfunction

  function automatic int wheel_out(input trc_pkg::trc_wheel_t w, input int i);
    byte c;
    c = wheel_wiring[int'(w)][i];
    return int'(c - LETTER_A);
  endfunction

  function automatic int wheel_in(input trc_pkg::trc_wheel_t w, input int y);
    int idx;
    idx = 0;
    for (int i = 0; i < 26; i++) begin
      if (wheel_out(w, i) == y) idx = i;
    end
    return idx;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch @%0d: %s got %0d want %0d", cycle_count, what, got, want);
    errors++;
  endtask

  task automatic load_rotors();
    for (int k = 0; k < 3; k++) rot_pos[k] = fold26_tb(cfg_start[k]);
  endtask

  // model of one accepted transaction
  task automatic predict_transaction(input logic k, input logic [4:0] raw);
    trc_pkg::trc_wheel_t wh [3];
    int x;
    if (k) begin
      load_rotors();
      return;
    end
    case (trc_pkg::trc_order_t'(cfg_order))
      trc_pkg::ORDER_213: wh = '{trc_pkg::WHEEL_II, trc_pkg::WHEEL_I, trc_pkg::WHEEL_III};
      trc_pkg::ORDER_231: wh = '{trc_pkg::WHEEL_II, trc_pkg::WHEEL_III, trc_pkg::WHEEL_I};
      trc_pkg::ORDER_312: wh = '{trc_pkg::WHEEL_III, trc_pkg::WHEEL_I, trc_pkg::WHEEL_II};
      trc_pkg::ORDER_321: wh = '{trc_pkg::WHEEL_III, trc_pkg::WHEEL_II, trc_pkg::WHEEL_I};
      trc_pkg::ORDER_132: wh = '{trc_pkg::WHEEL_I, trc_pkg::WHEEL_III, trc_pkg::WHEEL_II};
      default:            wh = '{trc_pkg::WHEEL_I, trc_pkg::WHEEL_II, trc_pkg::WHEEL_III};
    endcase
    x = plugboard[fold26_tb(raw)];
    for (int j = 0; j < 3; j++) x = wheel_out(wh[j], (x + rot_pos[j]) % 26);
    x = (x + 13) % 26;
    for (int j = 2; j >= 0; j--) x = (wheel_in(wh[j], x) + 26 - rot_pos[j]) % 26;
    pending_letters.push_back(5'(plugboard[x]));
    // odometer: fast, middle, slow
    if (rot_pos[0] == 25) begin
      rot_pos[0] = 0;
      if (rot_pos[1] == 25) begin
        rot_pos[1] = 0;
        rot_pos[2] = (rot_pos[2] == 25) ? 0 : rot_pos[2] + 1;
      end else begin
        rot_pos[1]++;
      end
    end else begin
      rot_pos[0]++;
    end
  endtask

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_item(input logic k, input logic [4:0] l);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.kind <= k;
    item_ch.letter_in <= l;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predict_transaction(k, l);
    @(negedge clk);
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    while (pending_letters.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input trc_pkg::trc_reg_t r, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= trc_pkg::ADDR_W'({r, 2'b00});
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (r)
      trc_pkg::REG_ROTOR_ORDER:  cfg_order = v[2:0];
      trc_pkg::REG_START_FAST:   cfg_start[0] = v[4:0];
      trc_pkg::REG_START_MIDDLE: cfg_start[1] = v[4:0];
      trc_pkg::REG_START_SLOW:   cfg_start[2] = v[4:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // result receiver; long hold-offs are requested through hold_req
  initial begin
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_req) begin
        hold_served = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_letters.size() == 0) begin
        report_mismatch("unexpected letter_out", int'(result_ch.letter_out), -1);
      end else begin
        logic [4:0] want;
        want = pending_letters.pop_front();
        if (result_ch.letter_out !== want)
          report_mismatch("letter_out", int'(result_ch.letter_out), int'(want));
      end
    end
  end

  task automatic test_letter_extremes();
    send_item(1'b0, 5'd0);
    send_item(1'b0, 5'd25);
    send_item(1'b0, 5'd26);
    send_item(1'b0, 5'd31);
    // restart ignores letter_in
    send_item(1'b1, 5'd31);
    send_item(1'b0, 5'd13);
  endtask

  task automatic test_wheel_orders();
    for (int o = 0; o < 8; o++) begin
      settle();
      write_reg(trc_pkg::REG_ROTOR_ORDER, 32'(o));
      send_item(1'b0, 5'($urandom_range(31)));
    end
  endtask

  task automatic test_odometer_wrap();
    settle();
    write_reg(trc_pkg::REG_ROTOR_ORDER, 32'(trc_pkg::ORDER_123));
    write_reg(trc_pkg::REG_START_FAST, 32'd25);
    write_reg(trc_pkg::REG_START_MIDDLE, 32'd25);
    write_reg(trc_pkg::REG_START_SLOW, 32'd25);
    // start writes alone must not move the rotors
    send_item(1'b0, 5'd4);
    send_item(1'b1, 5'd0);
    send_item(1'b0, 5'd4);
    send_item(1'b0, 5'd4);
  endtask

  task automatic test_start_fold();
    settle();
    write_reg(trc_pkg::REG_ROTOR_ORDER, 32'd7);
    write_reg(trc_pkg::REG_START_FAST, 32'd31);
    write_reg(trc_pkg::REG_START_MIDDLE, 32'd26);
    write_reg(trc_pkg::REG_START_SLOW, 32'd30);
    send_item(1'b1, 5'd17);
    send_item(1'b0, 5'd9);
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int count);
    logic [4:0] mid;
    settle();
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    mid = ($urandom_range(3) == 0) ? 5'd25 : 5'($urandom_range(31));
    write_reg(trc_pkg::REG_ROTOR_ORDER, ($urandom & ~32'h7) | 32'($urandom_range(7)));
    write_reg(trc_pkg::REG_START_FAST, ($urandom & ~32'h1f) | 32'($urandom_range(31)));
    write_reg(trc_pkg::REG_START_MIDDLE, ($urandom & ~32'h1f) | 32'(mid));
    write_reg(trc_pkg::REG_START_SLOW, ($urandom & ~32'h1f) | 32'($urandom_range(31)));
    send_item(1'b1, 5'($urandom_range(31)));
    for (int n = 0; n < count; n++)
      send_item($urandom_range(99) < 8, 5'($urandom_range(31)));
  endtask

  task automatic test_result_stall();
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    for (int n = 0; n < 30; n++)
      send_item($urandom_range(99) < 5, 5'($urandom_range(31)));
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    item_ch.valid = 1'b0;
    item_ch.kind = 1'b0;
    item_ch.letter_in = '0;
    cfg_order = '0;
    cfg_start = '{5'd0, 5'd0, 5'd0};
    load_rotors();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_letter_extremes();
    test_wheel_orders();
    test_odometer_wrap();
    test_start_fold();
    test_random_traffic(36, 75, 520);
    test_result_stall();
    test_random_traffic(75, 36, 520);
    test_random_traffic(0, 0, 480);

    item_ch.valid <= 1'b0;
    while (pending_letters.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ three_rotor_cipher.f @@
hw/rtl/trc_pkg.sv
hw/rtl/trc_if.sv
hw/rtl/trc_regs.sv
hw/rtl/trc_rotor_ctrl.sv
hw/rtl/trc_datapath.sv
hw/rtl/three_rotor_cipher.sv
hw/rtl/trc_checker.sv
tb/sv/three_rotor_cipher_test.sv
